[hdl/anem_pkg.sv]
`timescale 1ns / 1ps

package anem_pkg;

    // input item kinds carried on tuser
    localparam logic [1:0] OP_SEED_WORD = 2'd0;
    localparam logic [1:0] OP_SEED_ADC  = 2'd1;
    localparam logic [1:0] OP_GEN_ADC   = 2'd2;

    localparam logic [15:0] MIXER_RESET     = 16'hACE1;
    localparam logic [15:0] BYTE_COUNT_INIT = 16'd1;
    localparam logic [4:0]  LAST_POSITION   = 5'd31;

    // running state of the mixer between items
    typedef struct packed {
        logic [15:0] mixer;
        logic [4:0]  pos;
        logic [15:0] held;
        logic [15:0] diff1;
        logic        par;
        logic [7:0]  acc;
        logic [15:0] done;
    } t_state;

    // what one item leaves for the output side
    typedef struct packed {
        logic       emit;
        logic [7:0] byte_val;
        logic       last;
    } t_result;

    localparam t_state STATE_RESET = '{
        mixer: MIXER_RESET,
        pos:   5'd0,
        held:  16'd0,
        diff1: 16'd0,
        par:   1'b0,
        acc:   8'd0,
        done:  16'd0
    };

    // one shift: feedback from bits 0, 2, 3 and 5 enters at the top
    function automatic logic [15:0] mixer_step(input logic [15:0] r);
        return {r[0] ^ r[2] ^ r[3] ^ r[5], r[15:1]};
    endfunction

endpackage

[hdl/anem_datapath.sv]
`timescale 1ns / 1ps

module anem_datapath (
    input  anem_pkg::t_state  i_state,
    input  logic [1:0]        i_opcode,
    input  logic [15:0]       i_seed_word,
    input  logic [15:0]       i_adc_sample,
    input  logic [15:0]       i_byte_count,
    output anem_pkg::t_state  o_state,
    output anem_pkg::t_result o_result
);

    // next state and result for one item
    always_comb begin
        logic [15:0] v_seed;
        logic [15:0] v_sub;
        logic [15:0] v_d;
        logic [15:0] v_s1;
        logic [15:0] v_s2;
        logic [15:0] v_done_inc;
        logic        v_last;

        o_state  = i_state;
        o_result = '0;
        v_seed     = (i_opcode == anem_pkg::OP_SEED_WORD) ? i_seed_word : i_adc_sample;
        v_sub      = i_adc_sample - i_state.held;
        v_d        = i_state.diff1 ^ v_sub;
        v_s1       = '0;
        v_s2       = '0;
        v_done_inc = i_state.done + 16'd1;
        v_last     = 1'b0;

        unique case (i_opcode) inside
            anem_pkg::OP_SEED_WORD, anem_pkg::OP_SEED_ADC: begin
                // seed items mix in and restart all counts
                o_state.mixer = anem_pkg::mixer_step(i_state.mixer ^ v_seed);
                o_state.pos   = '0;
                o_state.par   = 1'b0;
                o_state.acc   = '0;
                o_state.done  = '0;
            end
            anem_pkg::OP_GEN_ADC: begin
                // group of four samples: two differences and lsb parity
                case (i_state.pos[1:0])
                    2'd0: begin
                        o_state.held = i_adc_sample;
                        o_state.par  = i_adc_sample[0];
                    end
                    2'd1: begin
                        o_state.diff1 = v_sub;
                        o_state.par   = i_state.par ^ i_adc_sample[0];
                    end
                    2'd2: begin
                        o_state.held = i_adc_sample;
                        o_state.par  = i_state.par ^ i_adc_sample[0];
                    end
                    default: begin
                        o_state.mixer = i_state.mixer ^ v_d;
                        o_state.acc   = {i_state.acc[6:0],
                                         i_state.par ^ i_adc_sample[0] ^ v_d[1]};
                    end
                endcase

                // byte finished after the last sample of the eighth group
                if (i_state.pos != anem_pkg::LAST_POSITION) begin
                    o_state.pos = i_state.pos + 5'd1;
                end else begin
                    v_s1   = anem_pkg::mixer_step(o_state.mixer);
                    v_s2   = anem_pkg::mixer_step(v_s1);
                    v_last = (v_done_inc == i_byte_count);
                    o_result.emit     = 1'b1;
                    o_result.byte_val = o_state.acc ^ v_s1[7:0] ^ v_s2[15:8];
                    o_result.last     = v_last;
                    o_state.mixer = v_s2;
                    o_state.pos   = '0;
                    o_state.acc   = '0;
                    o_state.par   = 1'b0;
                    o_state.done  = v_last ? 16'd0 : v_done_inc;
                end
            end
            default: begin
                // unused opcode leaves everything as it is
                o_state = i_state;
            end
        endcase
    end

endmodule

[hdl/adc_noise_lfsr_entropy_mixer.sv]
`timescale 1ns / 1ps

// Entropy mixer fed with raw ADC samples, one byte out per 32 samples.
// Input channel s_axis: tuser is the item kind (seed word, seed ADC
// sample, generation sample); tdata carries the seed word and the sample.
// Output channel m_axis: tdata is the finished byte, tlast marks the byte
// that completes the configured request length.
// i_cfg_we / i_cfg_wdata write the byte count per request; write it only
// while no item is in flight. Zero acts as 65536.
// Throughput is one item per clock unless a byte must wait on a stalled
// receiver: an input register and a result register enclose a single pass
// of next-state logic, and the state register closes its loop. The result
// register drives m_axis; it takes a byte as the item completing it fires.
// When the receiver stalls, the result register holds the byte, the
// pipeline keeps taking items that give no byte, and tready drops only
// when a second byte would have to wait.
// Reset (i_rst_n low, synchronous) loads the mixer with 0xACE1, clears
// every count and sets the byte count to one; pending items are dropped.
module adc_noise_lfsr_entropy_mixer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // seed_word [15:0], adc_sample [31:16]
    input  logic [1:0]  s_axis_tuser,  // opcode [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // random_byte [7:0]
    output logic        m_axis_tlast
);

    logic              r_in_valid;
    logic [1:0]        r_in_op;
    logic [15:0]       r_in_word;
    logic [15:0]       r_in_smp;
    logic [15:0]       r_byte_count;
    anem_pkg::t_state  r_state;
    anem_pkg::t_state  n_state;
    anem_pkg::t_result n_result;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              w_fire;
    logic              w_in_take;

    // the held item moves on when the result register is free or draining, or when it gives no byte
    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready || !n_result.emit);
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= anem_pkg::BYTE_COUNT_INIT;
        end else if (i_cfg_we) begin
            r_byte_count <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_op   <= s_axis_tuser;
            r_in_word <= s_axis_tdata[15:0];
            r_in_smp  <= s_axis_tdata[31:16];
        end
    end

    // next-state logic for one item
    anem_datapath u_datapath (
        .i_state      (r_state),
        .i_opcode     (r_in_op),
        .i_seed_word  (r_in_word),
        .i_adc_sample (r_in_smp),
        .i_byte_count (r_byte_count),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // mixer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= anem_pkg::STATE_RESET;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && n_result.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && n_result.emit) begin
            r_out_byte <= n_result.byte_val;
            r_out_last <= n_result.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

endmodule
